// ===== rtl/art_pkg.sv =====
package art_pkg;

  localparam int ART_MAX_REGIONS = 16;
  localparam int ART_ADDR_W      = 64;
  localparam int ART_IDX_OUT_W   = 4;

  typedef enum logic [2:0] {
    ART_ADD      = 3'd0,
    ART_REMOVE   = 3'd1,
    ART_VALIDATE = 3'd2,
    ART_PREFIX   = 3'd3,
    ART_OVERLAP  = 3'd4
  } art_act_t;

  typedef enum logic [1:0] {
    ART_ST_OK     = 2'd0,
    ART_ST_MISS   = 2'd1,
    ART_ST_BADARG = 2'd2,
    ART_ST_FULL   = 2'd3
  } art_status_t;

  // One table entry as held in the region memory
  typedef struct packed {
    logic [ART_ADDR_W-1:0] base;
    logic [ART_ADDR_W-1:0] size;
  } art_entry_t;

  // Per-entry match flags, one for each kind of search
  typedef struct packed {
    logic rm;   // exact base and size match
    logic val;  // entry holds the whole range
    logic pre;  // entry holds the start address
    logic ovl;  // entry holds the first or the last byte
  } art_hit_t;

endpackage

// ===== rtl/art_store.sv =====
module art_store
  import art_pkg::*;
#(
  parameter int MAX_REGIONS = ART_MAX_REGIONS,
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  art_entry_t    wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output art_entry_t    rdata
);

  art_entry_t mem_r [MAX_REGIONS];
  art_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/art_match.sv =====
module art_match
  import art_pkg::*;
#(
  parameter int MAX_REGIONS = ART_MAX_REGIONS,
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  flush,
  input  logic                  in_vld,
  input  logic [IW-1:0]         in_idx,
  input  art_entry_t            in_entry,
  input  logic [ART_ADDR_W-1:0] addr,
  input  logic [ART_ADDR_W-1:0] len,
  input  logic [ART_ADDR_W:0]   last,
  output logic                  busy,
  output art_hit_t              hit,
  output logic [IW-1:0]         hit_idx,
  output logic [ART_ADDR_W-1:0] avail
);

  logic                  vld_r;
  logic [IW-1:0]         idx_r;
  logic [ART_ADDR_W-1:0] base_r;
  logic [ART_ADDR_W-1:0] size_r;
  logic [ART_ADDR_W:0]   end_r;

  logic                  ge_a;
  logic                  lt_a;
  logic                  ge_l;
  logic                  lt_l;
  logic [ART_ADDR_W:0]   diff;

  // Register the entry together with its 65-bit end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld && !flush;
    end
    idx_r  <= in_idx;
    base_r <= in_entry.base;
    size_r <= in_entry.size;
    end_r  <= {1'b0, in_entry.base} + {1'b0, in_entry.size};
  end

  always_comb begin
    ge_a = addr >= base_r;
    lt_a = {1'b0, addr} < end_r;
    ge_l = last >= {1'b0, base_r};
    lt_l = last < end_r;
    diff = end_r - {1'b0, addr};

    hit.rm  = vld_r && (base_r == addr) && (size_r == len);
    hit.val = vld_r && ge_a && lt_l;
    hit.pre = vld_r && ge_a && lt_a;
    hit.ovl = vld_r && ((ge_a && lt_a) || (ge_l && lt_l));
  end

  assign busy    = vld_r;
  assign hit_idx = idx_r;
  assign avail   = diff[ART_ADDR_W-1:0];

endmodule

// ===== rtl/address_region_table_unit.sv =====
// Add and rejected requests go straight to the done state, which registers the
// result once the output is free. Searches read one entry per cycle from the
// region memory's single read port; a remove hit then shifts each later entry
// down one per cycle, reading it and writing it back one place lower.
// One request at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) empties the table; region memory is not cleared.
module address_region_table_unit
  import art_pkg::*;
#(
  parameter int MAX_REGIONS = ART_MAX_REGIONS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] action, [66:3] base_addr, [130:67] length, [135:131] zero
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [2] index_valid, [6:3] found_index, [70:7] prefix_length, [71] zero
  output logic [71:0]  out_tdata
);

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int AW = ART_ADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  art_act_t         act_r, act_nxt;
  logic [AW-1:0]    a_r, a_nxt;
  logic [AW-1:0]    len_r, len_nxt;
  logic [AW:0]      last_r, last_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    iss_r, iss_nxt;
  logic             s1_vld_r, s1_vld_nxt;
  logic [IW-1:0]    s1_idx_r, s1_idx_nxt;
  logic             sh_vld_r, sh_vld_nxt;
  logic [IW-1:0]    sh_wr_r, sh_wr_nxt;
  art_status_t      res_status_r, res_status_nxt;
  logic             res_ivld_r, res_ivld_nxt;
  logic [IW-1:0]    res_idx_r, res_idx_nxt;
  logic [AW-1:0]    avail_r, avail_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [71:0]      out_data_r, out_data_nxt;

  // Request fields
  art_act_t         in_act;
  logic [AW-1:0]    in_base;
  logic [AW-1:0]    in_len;
  logic [AW:0]      in_last;
  logic             in_fire;

  // Memory ports
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  art_entry_t       mem_wdata;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;
  art_entry_t       mem_rdata;

  // Match stage
  logic             m_flush;
  logic             m_busy;
  art_hit_t         m_hit;
  logic [IW-1:0]    m_idx;
  logic [AW-1:0]    m_avail;
  logic             hit_now;
  logic [AW-1:0]    prefix;

  assign in_act    = art_act_t'(in_tdata[2:0]);
  assign in_base   = in_tdata[66:3];
  assign in_len    = in_tdata[130:67];
  assign in_last   = {1'b0, in_base} + {1'b0, in_len} - {{AW{1'b0}}, 1'b1};
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  art_store #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  art_match #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .flush   (m_flush),
    .in_vld  (s1_vld_r),
    .in_idx  (s1_idx_r),
    .in_entry(mem_rdata),
    .addr    (a_r),
    .len     (len_r),
    .last    (last_r),
    .busy    (m_busy),
    .hit     (m_hit),
    .hit_idx (m_idx),
    .avail   (m_avail)
  );

  // Pick the flag that answers the current request
  always_comb begin
    case (act_r)
      ART_REMOVE:   hit_now = m_hit.rm;
      ART_VALIDATE: hit_now = m_hit.val;
      ART_PREFIX:   hit_now = m_hit.pre;
      ART_OVERLAP:  hit_now = m_hit.ovl;
      default:      hit_now = 1'b0;
    endcase
  end

  assign prefix = (avail_r < len_r) ? avail_r : len_r;

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    a_nxt          = a_r;
    len_nxt        = len_r;
    last_nxt       = last_r;
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    s1_vld_nxt     = 1'b0;
    s1_idx_nxt     = s1_idx_r;
    sh_vld_nxt     = 1'b0;
    sh_wr_nxt      = sh_wr_r;
    res_status_nxt = res_status_r;
    res_ivld_nxt   = res_ivld_r;
    res_idx_nxt    = res_idx_r;
    avail_nxt      = avail_r;
    out_vld_nxt    = out_vld_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[IW-1:0];
    mem_wdata      = '{base: in_base, size: in_len};
    mem_re         = 1'b0;
    mem_raddr      = iss_r[IW-1:0];
    m_flush        = 1'b0;

    // Drop the result once the sink has taken it
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt        = in_act;
          a_nxt          = in_base;
          len_nxt        = in_len;
          last_nxt       = in_last;
          iss_nxt        = '0;
          res_ivld_nxt   = 1'b0;
          res_idx_nxt    = '0;
          res_status_nxt = ART_ST_MISS;
          case (in_act)
            ART_ADD: begin
              state_nxt = S_DONE;
              if (in_len == '0) begin
                res_status_nxt = ART_ST_BADARG;
              end else if (count_r >= CW'(MAX_REGIONS)) begin
                res_status_nxt = ART_ST_FULL;
              end else begin
                // Append at the fill position
                mem_we         = 1'b1;
                count_nxt      = count_r + CW'(1);
                res_status_nxt = ART_ST_OK;
              end
            end
            ART_REMOVE: begin
              state_nxt = S_SCAN;
            end
            ART_VALIDATE: begin
              if (in_len == '0 || in_last[AW]) begin
                res_status_nxt = ART_ST_BADARG;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ART_PREFIX, ART_OVERLAP: begin
              if (in_len == '0) begin
                res_status_nxt = ART_ST_BADARG;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = ART_ST_BADARG;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit_now) begin
          // First hit in table order wins: flush the entries behind it
          m_flush        = 1'b1;
          res_status_nxt = ART_ST_OK;
          res_idx_nxt    = m_idx;
          res_ivld_nxt   = (act_r == ART_OVERLAP);
          avail_nxt      = m_avail;
          if (act_r == ART_REMOVE) begin
            iss_nxt   = CW'(m_idx) + CW'(1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (iss_r < count_r) begin
          mem_re     = 1'b1;
          s1_vld_nxt = 1'b1;
          s1_idx_nxt = iss_r[IW-1:0];
          iss_nxt    = iss_r + CW'(1);
        end else if (!s1_vld_r && !m_busy) begin
          state_nxt = S_DONE;
        end
      end

      S_SHIFT: begin
        // Write back the entry read last cycle one place lower
        if (sh_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = sh_wr_r;
          mem_wdata = mem_rdata;
        end
        if (iss_r < count_r) begin
          mem_re     = 1'b1;
          sh_vld_nxt = 1'b1;
          sh_wr_nxt  = iss_r[IW-1:0] - IW'(1);
          iss_nxt    = iss_r + CW'(1);
        end else if (!sh_vld_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt        = 1'b1;
          out_data_nxt       = '0;
          out_data_nxt[1:0]  = res_status_r;
          out_data_nxt[2]    = res_ivld_r;
          out_data_nxt[6:3]  = res_ivld_r ? ART_IDX_OUT_W'(res_idx_r) : '0;
          out_data_nxt[70:7] = (act_r == ART_PREFIX && res_status_r == ART_ST_OK)
                               ? prefix : '0;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      iss_r     <= '0;
      s1_vld_r  <= 1'b0;
      sh_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      iss_r     <= iss_nxt;
      s1_vld_r  <= s1_vld_nxt;
      sh_vld_r  <= sh_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    act_r        <= act_nxt;
    a_r          <= a_nxt;
    len_r        <= len_nxt;
    last_r       <= last_nxt;
    s1_idx_r     <= s1_idx_nxt;
    sh_wr_r      <= sh_wr_nxt;
    res_status_r <= res_status_nxt;
    res_ivld_r   <= res_ivld_nxt;
    res_idx_r    <= res_idx_nxt;
    avail_r      <= avail_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/sv/address_region_checker.sv =====
module address_region_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  // [2:0] action, [66:3] base_addr, [130:67] length, [135:131] zero
  input  logic [135:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [2] index_valid, [6:3] found_index, [70:7] prefix_length, [71] zero
  input  logic [71:0]  out_tdata,
  output int           mismatches,
  output int           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  localparam logic [63:0] ALL_ONES = '1;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    art_status_t status;
    logic        index_valid;
    logic [3:0]  found_index;
    logic [63:0] prefix_length;
  } region_reply_t;

  logic [63:0]   tbl_base [ART_MAX_REGIONS];
  logic [63:0]   tbl_size [ART_MAX_REGIONS];
  int            tbl_count;
  region_reply_t due_replies [$];
  int            fault_total;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    fault_total = 0;
    tbl_count   = 0;
  end

  // Carry out one request on the shadow table and work out its reply
  task automatic apply_request(input logic [2:0] act, input logic [63:0] addr,
                               input logic [63:0] len, output region_reply_t r);
    logic [64:0] first_byte;
    logic [64:0] last_byte;
    logic [64:0] lo;
    logic [64:0] hi;
    logic [63:0] off;
    logic [63:0] avail;
    int          i;
    int          k;
    bit          found;
    r.status        = ART_ST_BADARG;
    r.index_valid   = 1'b0;
    r.found_index   = '0;
    r.prefix_length = '0;
    found           = 1'b0;
    case (act)
      ART_ADD: begin
        if (len == 0) begin
          r.status = ART_ST_BADARG;
        end else if (tbl_count >= ART_MAX_REGIONS) begin
          r.status = ART_ST_FULL;
        end else begin
          tbl_base[tbl_count] = addr;
          tbl_size[tbl_count] = len;
          tbl_count++;
          r.status = ART_ST_OK;
        end
      end
      ART_REMOVE: begin
        r.status = ART_ST_MISS;
        for (i = 0; i < tbl_count && !found; i++) begin
          if (tbl_base[i] == addr && tbl_size[i] == len) begin
            for (k = i; k + 1 < tbl_count; k++) begin
              tbl_base[k] = tbl_base[k + 1];
              tbl_size[k] = tbl_size[k + 1];
            end
            tbl_count--;
            r.status = ART_ST_OK;
            found    = 1'b1;
          end
        end
      end
      ART_VALIDATE: begin
        if (len == 0 || addr > ALL_ONES - (len - 64'd1)) begin
          r.status = ART_ST_BADARG;
        end else begin
          r.status = ART_ST_MISS;
          for (i = 0; i < tbl_count && !found; i++) begin
            if (addr >= tbl_base[i]) begin
              off = addr - tbl_base[i];
              if (off < tbl_size[i] && len <= tbl_size[i] - off) begin
                r.status = ART_ST_OK;
                found    = 1'b1;
              end
            end
          end
        end
      end
      ART_PREFIX: begin
        if (len == 0) begin
          r.status = ART_ST_BADARG;
        end else begin
          r.status = ART_ST_MISS;
          for (i = 0; i < tbl_count && !found; i++) begin
            if (addr >= tbl_base[i]) begin
              off = addr - tbl_base[i];
              if (off < tbl_size[i]) begin
                avail           = tbl_size[i] - off;
                r.prefix_length = (avail < len) ? avail : len;
                r.status        = ART_ST_OK;
                found           = 1'b1;
              end
            end
          end
        end
      end
      ART_OVERLAP: begin
        if (len == 0) begin
          r.status = ART_ST_BADARG;
        end else begin
          // ends held 65 bits wide so that nothing wraps
          first_byte = {1'b0, addr};
          last_byte  = {1'b0, addr} + {1'b0, len} - 65'd1;
          r.status   = ART_ST_MISS;
          for (i = 0; i < tbl_count && !found; i++) begin
            lo = {1'b0, tbl_base[i]};
            hi = lo + {1'b0, tbl_size[i]};
            if ((first_byte >= lo && first_byte < hi) ||
                (last_byte >= lo && last_byte < hi)) begin
              r.status      = ART_ST_OK;
              r.index_valid = 1'b1;
              r.found_index = i[3:0];
              found         = 1'b1;
            end
          end
        end
      end
      default: r.status = ART_ST_BADARG;
    endcase
  endtask

  always @(posedge clk) begin : watch
    region_reply_t want;
    region_reply_t got;
    if (!rst_n) begin
      tbl_count = 0;
      due_replies.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        apply_request(in_tdata[2:0], in_tdata[66:3], in_tdata[130:67], want);
        due_replies.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.status        = art_status_t'(out_tdata[1:0]);
        got.index_valid   = out_tdata[2];
        got.found_index   = out_tdata[6:3];
        got.prefix_length = out_tdata[70:7];
        if (due_replies.size() == 0) begin
          if (fault_total < REPORT_LIMIT)
            $display("%0t: reply with no request outstanding: %h", $realtime, out_tdata);
          fault_total++;
        end else begin
          want = due_replies.pop_front();
          if (got.status !== want.status || got.index_valid !== want.index_valid ||
              got.found_index !== want.found_index ||
              got.prefix_length !== want.prefix_length) begin
            if (fault_total < REPORT_LIMIT)
              $display("%0t: reply mismatch exp st=%0d iv=%0b idx=%0d pre=%h",
                       $realtime, want.status, want.index_valid, want.found_index,
                       want.prefix_length, "  got st=%0d iv=%0b idx=%0d pre=%h",
                       got.status, got.index_valid, got.found_index, got.prefix_length);
            fault_total++;
          end
        end
      end
    end
    mismatches  <= fault_total;
    outstanding <= due_replies.size();
  end

endmodule

// ===== tb/sv/address_region_table_unit_tb.sv =====
module address_region_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  localparam logic [63:0] ALL_ONES    = '1;
  // action codes past find_overlap, all of them rejected by the block
  localparam logic [2:0]  ACT_SPARE_A = 3'd5;
  localparam logic [2:0]  ACT_SPARE_C = 3'd7;
  localparam int          RANDOM_REQS = 1300;
  // generous tail: a full table search plus a full shift of a remove
  localparam int          TAIL_CYCLES = 3 * ART_MAX_REGIONS + 8;

  typedef struct {
    logic [63:0] base;
    logic [63:0] size;
  } span_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  int           mismatches;
  int           outstanding;

  // Regions believed to be in the table; only steers the stimulus, never checks
  span_t        placed [$];
  int           sent_count = 0;
  int           stall_left = 0;
  logic [9:0]   rx_cycles  = '0;

  always #6 clk = ~clk;

  address_region_table_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  address_region_checker region_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Result side back-pressure: short and long stalls, and always ready while
  // the top two bits of rx_cycles are both set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 10'd1;
      if (rx_cycles[9:8] == 2'd3) begin
        out_tready <= 1'b1;
        stall_left <= 0;
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 20) begin
        out_tready <= 1'b0;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Addresses: half clustered low so that regions meet, some near the top, the rest random
  function automatic logic [63:0] rand_base();
    case ($urandom_range(0, 5))
      0, 1, 2: return 64'($urandom_range(0, 255)) << 8;
      3:       return ALL_ONES - 64'($urandom_range(0, 4095));
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [63:0] rand_size();
    case ($urandom_range(0, 11))
      0:          return 64'd1;
      1, 2, 3, 4: return 64'($urandom_range(1, 1024));
      5:          return 64'($urandom_range(1, 1 << 20));
      6, 7:       return rand_word();
      8:          return ALL_ONES;
      9, 10:      return 64'd1 << $urandom_range(0, 63);
      default:    return 64'd0;
    endcase
  endfunction

  // Sender gap: none in the last fifth of every stretch of 300 requests, else mostly short
  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if ((sent_count % 300) >= 240) return 0;
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drop valid for a while, optionally until every reply is back
  task automatic pause_sender(input int cycles, input bit until_drained);
    if (cycles > 0 || until_drained) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
      if (until_drained) begin
        do @(posedge clk); while (outstanding != 0);
      end
    end
  endtask

  // Offer one request, hold it until taken, then wait out a sender gap or until drained
  task automatic send_request(input logic [2:0] act, input logic [63:0] addr,
                              input logic [63:0] len, input bit drain_after);
    int i;
    bit gone;
    gone = 1'b0;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, len, addr, act};
    do @(posedge clk); while (!in_tready);
    sent_count++;
    // keep the steering list roughly in line with the table
    if (act == ART_ADD && len != 0 && placed.size() < ART_MAX_REGIONS) begin
      placed.push_back('{addr, len});
    end else if (act == ART_REMOVE) begin
      for (i = 0; i < placed.size() && !gone; i++) begin
        if (placed[i].base == addr && placed[i].size == len) begin
          placed.delete(i);
          gone = 1'b1;
        end
      end
    end
    pause_sender(drain_after ? 0 : sender_gap(), drain_after);
  endtask

  // Range near a known region: at its start, its last byte, just past, inside or
  // just below, with a length that fits exactly, overruns by one, or is random
  task automatic make_query(output logic [63:0] addr, output logic [63:0] len);
    span_t       s;
    logic [63:0] off;
    if (placed.size() == 0 || $urandom_range(0, 4) == 0) begin
      addr = rand_base();
      len  = rand_size();
    end else begin
      s = placed[$urandom_range(0, placed.size() - 1)];
      case ($urandom_range(0, 4))
        0:       off = 64'd0;
        1:       off = s.size - 64'd1;
        2:       off = s.size;
        3:       off = rand_word() % s.size;
        default: off = 64'd0 - 64'($urandom_range(1, 16));
      endcase
      addr = s.base + off;
      case ($urandom_range(0, 3))
        0:       len = s.size - off;
        1:       len = s.size - off + 64'd1;
        2:       len = rand_size();
        default: len = 64'($urandom_range(1, 16));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [2:0]  act;
    logic [63:0] addr;
    logic [63:0] len;
    span_t       s;
    bit          fill_phase;
    int          pick;
    int          n;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, zero sizes, a region ending exactly at the top of
    // the address space, a wrapping region, wrapping ranges, exact fits,
    // a last byte past 2^64, removes that miss and hit, and spare actions
    send_request(ART_VALIDATE, 64'h1000, 64'h10, 1'b0);
    send_request(ART_ADD, 64'h2000, 64'd0, 1'b0);
    send_request(ART_ADD, 64'd0, 64'd1, 1'b0);
    send_request(ART_ADD, ALL_ONES - 64'hF, 64'h10, 1'b0);
    send_request(ART_ADD, 64'h1000, 64'h100, 1'b0);
    send_request(ART_ADD, ALL_ONES, ALL_ONES, 1'b0);
    send_request(ART_VALIDATE, 64'h1000, 64'h100, 1'b0);
    send_request(ART_VALIDATE, 64'h1080, 64'h81, 1'b0);
    send_request(ART_VALIDATE, 64'h1000, 64'd0, 1'b0);
    send_request(ART_VALIDATE, ALL_ONES, 64'd2, 1'b0);
    send_request(ART_VALIDATE, ALL_ONES - 64'hF, 64'h10, 1'b0);
    send_request(ART_PREFIX, 64'h10F0, ALL_ONES, 1'b0);
    send_request(ART_PREFIX, 64'h1010, 64'h8, 1'b0);
    send_request(ART_PREFIX, 64'h1000, 64'd0, 1'b0);
    send_request(ART_PREFIX, 64'h2000, 64'h40, 1'b0);
    send_request(ART_OVERLAP, 64'hF00, 64'h101, 1'b0);
    send_request(ART_OVERLAP, 64'h10, ALL_ONES, 1'b0);
    send_request(ART_OVERLAP, 64'h1000, 64'd0, 1'b0);
    send_request(ART_OVERLAP, 64'h5000, 64'h10, 1'b0);
    send_request(ART_REMOVE, 64'h1000, 64'h101, 1'b0);
    send_request(ART_REMOVE, 64'h1000, 64'h100, 1'b0);
    send_request(ART_OVERLAP, 64'h1000, 64'h100, 1'b0);
    for (pick = ACT_SPARE_A; pick <= ACT_SPARE_C; pick++)
      send_request(3'(pick), rand_word(), rand_word(), pick == ACT_SPARE_C);

    // Random: alternate stretches that fill the table to full and that empty it
    for (n = 0; n < RANDOM_REQS; n++) begin
      fill_phase = ((n / 120) % 2) == 0;
      pick       = $urandom_range(0, 99);
      if (pick < (fill_phase ? 40 : 12)) begin
        act  = ART_ADD;
        addr = rand_base();
        len  = ($urandom_range(0, 19) == 0) ? 64'd0 : rand_size();
        if (len == 0 && $urandom_range(0, 1) == 0) len = 64'($urandom_range(1, 4096));
      end else if (pick < (fill_phase ? 50 : 45)) begin
        act = ART_REMOVE;
        if (placed.size() != 0 && $urandom_range(0, 4) != 0) begin
          s    = placed[$urandom_range(0, placed.size() - 1)];
          addr = s.base;
          len  = ($urandom_range(0, 4) == 0) ? s.size + 64'd1 : s.size;
        end else begin
          addr = rand_base();
          len  = rand_size();
        end
      end else if (pick < 95) begin
        case ($urandom_range(0, 2))
          0:       act = ART_VALIDATE;
          1:       act = ART_PREFIX;
          default: act = ART_OVERLAP;
        endcase
        make_query(addr, len);
      end else begin
        act  = 3'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
        addr = rand_word();
        len  = rand_word();
      end
      // hold off halfway through and after the last request until the block has answered everything
      send_request(act, addr, len, n == RANDOM_REQS / 2 || n == RANDOM_REQS - 1);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run
  initial begin : watchdog
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== address_region_table_unit.f =====
rtl/art_pkg.sv
rtl/art_store.sv
rtl/art_match.sv
rtl/address_region_table_unit.sv
tb/sv/address_region_checker.sv
tb/sv/address_region_table_unit_tb.sv
